[src/ps2hl_pkg.sv]
// ----------------------------------------------------------------------------
// ps2hl_pkg
// Shared types, codes and constants for the PS/2 host link core.
// ----------------------------------------------------------------------------
package ps2hl_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_LED  = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // Link mode, also reported on the result channel
  typedef enum logic [1:0] {
    MODE_RECEIVE  = 2'd0,
    MODE_SEND_CMD = 2'd1,
    MODE_SEND_LED = 2'd2,
    MODE_WAIT     = 2'd3
  } mode_t;

  localparam logic [7:0] CMD_SET_LEDS = 8'hED;
  localparam logic [7:0] REPLY_ACK    = 8'hFA;
  localparam logic [7:0] REPLY_RESEND = 8'hFE;

  // Frame bit positions (start bit is position 0)
  localparam logic [3:0] POS_PARITY = 4'd9;
  localparam logic [3:0] POS_STOP   = 4'd10;
  localparam logic [3:0] POS_ACK    = 4'd11;

  localparam int FIFO_DEPTH_DEFAULT = 16;

  // Request from the link controller to the receive FIFO
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_req_t;

  // Per-item result fields produced by the link controller
  typedef struct packed {
    logic        drive_valid;
    logic        drive_level;
    logic        start_request;
    logic        send_failed;
    logic [15:0] frame_errors;
    mode_t       link_mode;
  } link_res_t;

  // Odd parity bit over one byte
  function automatic logic odd_parity(input logic [7:0] v);
    odd_parity = ~(^v);
  endfunction

endpackage

[src/ps2hl_fifo_mem.sv]
// ----------------------------------------------------------------------------
// ps2hl_fifo_mem
// Ring FIFO of received bytes in a synchronous memory, with a registered read.
// ----------------------------------------------------------------------------
module ps2hl_fifo_mem #(
  parameter int FIFO_DEPTH = ps2hl_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ps2hl_pkg::fifo_req_t req,
  output logic                 pop_hit,
  output logic [7:0]           rd_data_r
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] head_inc, tail_inc;
  logic             full, empty, push_ok;

  // Pointer arithmetic; one slot is kept free to tell full from empty
  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign full     = (head_inc == tail_r);
  assign empty    = (head_r == tail_r);
  assign push_ok  = req.push && !full;
  assign pop_hit  = req.pop && !empty;

  always_comb begin
    head_nxt = push_ok ? head_inc : head_r;
    tail_nxt = pop_hit ? tail_inc : tail_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Storage: push and pop never share a transfer, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[head_inc] <= req.wdata;
    end
    if (pop_hit) begin
      rd_data_r <= mem[tail_inc];
    end
  end

endmodule

[src/ps2hl_link_ctrl.sv]
// ----------------------------------------------------------------------------
// ps2hl_link_ctrl
// Frame receiver, command sender and link mode control, one item per cycle while en is high.
// ----------------------------------------------------------------------------
module ps2hl_link_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [1:0]            operation,
  input  logic                  data_line,
  input  logic                  edge_gap_long,
  input  logic                  num_lock,
  input  logic                  caps_lock,
  input  logic                  scroll_lock,
  output ps2hl_pkg::fifo_req_t  fifo_req,
  output ps2hl_pkg::link_res_t  res
);

  ps2hl_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]  send_idx_r, send_idx_nxt;
  logic [3:0]  recv_idx_r, recv_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        parity_r, parity_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] err_r, err_nxt;
  logic [2:0]  led_r, led_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ps2hl_pkg::MODE_RECEIVE;
      send_idx_r <= '0;
      recv_idx_r <= '0;
      shift_r    <= '0;
      parity_r   <= 1'b1;
      stop_r     <= 1'b1;
      err_r      <= '0;
      led_r      <= '0;
    end else if (en) begin
      mode_r     <= mode_nxt;
      send_idx_r <= send_idx_nxt;
      recv_idx_r <= recv_idx_nxt;
      shift_r    <= shift_nxt;
      parity_r   <= parity_nxt;
      stop_r     <= stop_nxt;
      err_r      <= err_nxt;
      led_r      <= led_nxt;
    end
  end

  // Next state and per-item result
  always_comb begin
    logic [7:0] tx_byte;
    logic [2:0] bit_sel;
    logic [3:0] ri;
    logic       good;

    mode_nxt     = mode_r;
    send_idx_nxt = send_idx_r;
    recv_idx_nxt = recv_idx_r;
    shift_nxt    = shift_r;
    parity_nxt   = parity_r;
    stop_nxt     = stop_r;
    err_nxt      = err_r;
    led_nxt      = led_r;
    fifo_req     = '0;
    res.drive_valid   = 1'b0;
    res.drive_level   = 1'b1;
    res.start_request = 1'b0;
    res.send_failed   = 1'b0;

    tx_byte = (mode_r == ps2hl_pkg::MODE_SEND_CMD) ? ps2hl_pkg::CMD_SET_LEDS
                                                   : {5'b0, led_r};
    bit_sel = 3'(send_idx_r - 4'd1);
    ri      = recv_idx_r;
    good    = 1'b0;

    unique case (ps2hl_pkg::op_t'(operation))
      ps2hl_pkg::OP_EDGE: begin
        if (mode_r == ps2hl_pkg::MODE_SEND_CMD || mode_r == ps2hl_pkg::MODE_SEND_LED) begin
          // Sending: data bits, parity, stop, then sample the ack
          if (send_idx_r >= 4'd1 && send_idx_r <= 4'd8) begin
            res.drive_valid = 1'b1;
            res.drive_level = tx_byte[bit_sel];
            send_idx_nxt    = send_idx_r + 4'd1;
          end else if (send_idx_r == ps2hl_pkg::POS_PARITY) begin
            res.drive_valid = 1'b1;
            res.drive_level = ps2hl_pkg::odd_parity(tx_byte);
            send_idx_nxt    = send_idx_r + 4'd1;
          end else if (send_idx_r == ps2hl_pkg::POS_STOP) begin
            res.drive_valid = 1'b1;
            res.drive_level = 1'b1;
            send_idx_nxt    = send_idx_r + 4'd1;
          end else if (send_idx_r == ps2hl_pkg::POS_ACK) begin
            send_idx_nxt = '0;
            if (data_line) begin
              res.send_failed = 1'b1;
              mode_nxt        = ps2hl_pkg::MODE_RECEIVE;
            end else if (mode_r == ps2hl_pkg::MODE_SEND_LED) begin
              mode_nxt = ps2hl_pkg::MODE_RECEIVE;
            end else begin
              mode_nxt = ps2hl_pkg::MODE_WAIT;
            end
          end
        end else begin
          // Receiving: a long gap restarts the frame first
          if (edge_gap_long) begin
            ri         = '0;
            shift_nxt  = '0;
            parity_nxt = 1'b1;
            stop_nxt   = 1'b1;
          end
          if (ri == 4'd0 && data_line) begin
            err_nxt      = err_r + 16'd1;
            recv_idx_nxt = ri;
          end else begin
            if (ri >= 4'd1 && ri <= 4'd8) begin
              shift_nxt = shift_nxt | ({7'b0, data_line} << 3'(ri - 4'd1));
            end else if (ri == ps2hl_pkg::POS_PARITY) begin
              parity_nxt = data_line;
            end else if (ri == ps2hl_pkg::POS_STOP) begin
              stop_nxt = data_line;
            end
            recv_idx_nxt = ri + 4'd1;
            if (recv_idx_nxt >= ps2hl_pkg::POS_ACK) begin
              good = stop_nxt && (parity_nxt == ps2hl_pkg::odd_parity(shift_nxt));
              if (good) begin
                if (mode_r == ps2hl_pkg::MODE_RECEIVE) begin
                  fifo_req.push  = 1'b1;
                  fifo_req.wdata = shift_nxt;
                end else if (mode_r == ps2hl_pkg::MODE_WAIT) begin
                  if (shift_nxt == ps2hl_pkg::REPLY_ACK) begin
                    mode_nxt          = ps2hl_pkg::MODE_SEND_LED;
                    send_idx_nxt      = 4'd1;
                    res.start_request = 1'b1;
                  end else if (shift_nxt == ps2hl_pkg::REPLY_RESEND) begin
                    mode_nxt          = ps2hl_pkg::MODE_SEND_CMD;
                    send_idx_nxt      = 4'd1;
                    res.start_request = 1'b1;
                  end
                end
              end else begin
                err_nxt = err_r + 16'd1;
              end
              recv_idx_nxt = '0;
              shift_nxt    = '0;
            end
          end
        end
      end
      ps2hl_pkg::OP_LED: begin
        led_nxt           = {caps_lock, num_lock, scroll_lock};
        mode_nxt          = ps2hl_pkg::MODE_SEND_CMD;
        send_idx_nxt      = 4'd1;
        res.start_request = 1'b1;
      end
      ps2hl_pkg::OP_POP: begin
        fifo_req.pop = 1'b1;
      end
      ps2hl_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase

    // Only a transfer may touch the FIFO
    fifo_req.push = fifo_req.push && en;
    fifo_req.pop  = fifo_req.pop && en;

    res.frame_errors = err_nxt;
    res.link_mode    = mode_nxt;
  end

endmodule

[src/ps2_host_link_core.sv]
// ----------------------------------------------------------------------------
// ps2_host_link_core
// PS/2 keyboard host link: frame receive, LED command send, receive FIFO.
// ----------------------------------------------------------------------------
// Each input transfer carries one event (falling clock edge, LED request, pop
// or no-op) and yields exactly one result transfer from the output register.
// The core takes a new item every cycle while the output register is empty or
// being drained; the read of the receive FIFO memory is registered and lines
// up with the output register. The FIFO holds at most FIFO_DEPTH-1 bytes;
// bytes arriving while it is full are dropped.
// ----------------------------------------------------------------------------
module ps2_host_link_core #(
  parameter int FIFO_DEPTH = ps2hl_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_data_line,
  input  logic        in_edge_gap_long,
  input  logic        in_num_lock,
  input  logic        in_caps_lock,
  input  logic        in_scroll_lock,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_valid,
  output logic        out_drive_level,
  output logic        out_start_request,
  output logic        out_send_failed,
  output logic        out_byte_valid,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_frame_errors,
  output logic [1:0]  out_link_mode
);

  ps2hl_pkg::fifo_req_t fifo_req;
  ps2hl_pkg::link_res_t res;
  ps2hl_pkg::link_res_t res_r;
  logic                 pop_hit;
  logic [7:0]           rd_data;
  logic                 in_fire;
  logic                 out_valid_r, out_valid_nxt;
  logic                 byte_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  ps2hl_link_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (in_fire),
    .operation     (in_operation),
    .data_line     (in_data_line),
    .edge_gap_long (in_edge_gap_long),
    .num_lock      (in_num_lock),
    .caps_lock     (in_caps_lock),
    .scroll_lock   (in_scroll_lock),
    .fifo_req      (fifo_req),
    .res           (res)
  );

  ps2hl_fifo_mem #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (fifo_req),
    .pop_hit   (pop_hit),
    .rd_data_r (rd_data)
  );

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r        <= res;
      byte_valid_r <= pop_hit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_valid   = res_r.drive_valid;
  assign out_drive_level   = res_r.drive_level;
  assign out_start_request = res_r.start_request;
  assign out_send_failed   = res_r.send_failed;
  assign out_byte_valid    = byte_valid_r;
  assign out_byte_value    = byte_valid_r ? rd_data : 8'h00;
  assign out_frame_errors  = res_r.frame_errors;
  assign out_link_mode     = res_r.link_mode;

endmodule

[tb/ps2_host_link_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_link_checker
// Watches both channels of the PS/2 host link core, keeps its own model of
// the link (frame receiver, LED command sender, receive ring) and compares
// every result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module ps2_host_link_checker #(
  parameter int DEPTH = ps2hl_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_data_line,
  input  logic        in_edge_gap_long,
  input  logic        in_num_lock,
  input  logic        in_caps_lock,
  input  logic        in_scroll_lock,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_drive_valid,
  input  logic        out_drive_level,
  input  logic        out_start_request,
  input  logic        out_send_failed,
  input  logic        out_byte_valid,
  input  logic [7:0]  out_byte_value,
  input  logic [15:0] out_frame_errors,
  input  logic [1:0]  out_link_mode,
  output int          mismatch_total,
  output int          pending
);

  // One result transfer, field for field
  typedef struct packed {
    logic              drive_valid;
    logic              drive_level;
    logic              start_request;
    logic              send_failed;
    logic              byte_valid;
    logic [7:0]        byte_value;
    logic [15:0]       frame_errors;
    ps2hl_pkg::mode_t  link_mode;
  } link_obs_t;

  // Model state of the link
  ps2hl_pkg::mode_t lk_mode;
  logic [3:0]  tx_pos;
  logic [3:0]  rx_pos;
  logic [7:0]  rx_shift;
  logic        rx_par;
  logic        rx_stop;
  logic [15:0] err_cnt;
  logic [2:0]  led_req;
  logic [7:0]  rx_store [DEPTH];
  int          wr_ptr;
  int          rd_ptr;

  link_obs_t   link_expect[$];

  function automatic int ring_next(input int p);
    ring_next = (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // Kick off a host send: sequence starts from the first data bit
  function automatic void start_send(input ps2hl_pkg::mode_t m);
    lk_mode = m;
    tx_pos  = 4'd1;
  endfunction

  // Apply one item to the model and return the result it produces
  function automatic link_obs_t advance_link(input ps2hl_pkg::op_t op, input logic d,
                                             input logic g, input logic n,
                                             input logic c, input logic s);
    link_obs_t  r;
    logic [7:0] tx_byte;
    int         nxt;
    r = '0;
    r.drive_level = 1'b1;
    case (op)
      ps2hl_pkg::OP_EDGE: begin
        if (lk_mode == ps2hl_pkg::MODE_SEND_CMD || lk_mode == ps2hl_pkg::MODE_SEND_LED) begin
          // host is clocking out a byte; receiver frozen, gap ignored
          tx_byte = (lk_mode == ps2hl_pkg::MODE_SEND_CMD) ? ps2hl_pkg::CMD_SET_LEDS
                                                          : {5'd0, led_req};
          if (tx_pos >= 4'd1 && tx_pos <= 4'd8) begin
            r.drive_valid = 1'b1;
            r.drive_level = tx_byte[tx_pos - 4'd1];
            tx_pos++;
          end else if (tx_pos == ps2hl_pkg::POS_PARITY) begin
            r.drive_valid = 1'b1;
            r.drive_level = ~(^tx_byte);
            tx_pos++;
          end else if (tx_pos == ps2hl_pkg::POS_STOP) begin
            r.drive_valid = 1'b1;
            r.drive_level = 1'b1;
            tx_pos++;
          end else if (tx_pos == ps2hl_pkg::POS_ACK) begin
            tx_pos = 4'd0;
            if (d) begin
              r.send_failed = 1'b1;
              lk_mode = ps2hl_pkg::MODE_RECEIVE;
            end else if (lk_mode == ps2hl_pkg::MODE_SEND_LED) begin
              lk_mode = ps2hl_pkg::MODE_RECEIVE;
            end else begin
              lk_mode = ps2hl_pkg::MODE_WAIT;
            end
          end
        end else begin
          // long gap throws away any partial frame
          if (g) begin
            rx_pos   = 4'd0;
            rx_shift = 8'd0;
            rx_par   = 1'b1;
            rx_stop  = 1'b1;
          end
          if (rx_pos == 4'd0 && d) begin
            err_cnt++;
          end else begin
            if (rx_pos >= 4'd1 && rx_pos <= 4'd8)
              rx_shift[rx_pos - 4'd1] = rx_shift[rx_pos - 4'd1] | d;
            else if (rx_pos == ps2hl_pkg::POS_PARITY)
              rx_par = d;
            else if (rx_pos == ps2hl_pkg::POS_STOP)
              rx_stop = d;
            rx_pos++;
            if (rx_pos >= 4'd11) begin
              if (rx_stop && rx_par == ~(^rx_shift)) begin
                if (lk_mode == ps2hl_pkg::MODE_RECEIVE) begin
                  nxt = ring_next(wr_ptr);
                  // byte dropped when the ring is full
                  if (nxt != rd_ptr) begin
                    rx_store[nxt] = rx_shift;
                    wr_ptr = nxt;
                  end
                end else if (lk_mode == ps2hl_pkg::MODE_WAIT) begin
                  if (rx_shift == ps2hl_pkg::REPLY_ACK) begin
                    start_send(ps2hl_pkg::MODE_SEND_LED);
                    r.start_request = 1'b1;
                  end else if (rx_shift == ps2hl_pkg::REPLY_RESEND) begin
                    start_send(ps2hl_pkg::MODE_SEND_CMD);
                    r.start_request = 1'b1;
                  end
                end
              end else begin
                err_cnt++;
              end
              rx_pos   = 4'd0;
              rx_shift = 8'd0;
            end
          end
        end
      end
      ps2hl_pkg::OP_LED: begin
        led_req = {c, n, s};
        start_send(ps2hl_pkg::MODE_SEND_CMD);
        r.start_request = 1'b1;
      end
      ps2hl_pkg::OP_POP: begin
        if (rd_ptr != wr_ptr) begin
          rd_ptr       = ring_next(rd_ptr);
          r.byte_value = rx_store[rd_ptr];
          r.byte_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.frame_errors = err_cnt;
    r.link_mode    = lk_mode;
    advance_link   = r;
  endfunction

  task automatic note_fault(input string why, input link_obs_t w, input link_obs_t a);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%0t ns: %s", $time, why);
      $display("  expected dv=%0b dl=%0b start=%0b nack=%0b bv=%0b byte=%02h errs=%04h mode=%0d",
               w.drive_valid, w.drive_level, w.start_request, w.send_failed,
               w.byte_valid, w.byte_value, w.frame_errors, w.link_mode);
      $display("  actual   dv=%0b dl=%0b start=%0b nack=%0b bv=%0b byte=%02h errs=%04h mode=%0d",
               a.drive_valid, a.drive_level, a.start_request, a.send_failed,
               a.byte_valid, a.byte_value, a.frame_errors, a.link_mode);
    end
  endtask

  // Predict on every input transfer, compare on every output transfer
  always @(posedge clk) begin
    link_obs_t seen;
    link_obs_t want;
    if (!rst_n) begin
      lk_mode  = ps2hl_pkg::MODE_RECEIVE;
      tx_pos   = 4'd0;
      rx_pos   = 4'd0;
      rx_shift = 8'd0;
      rx_par   = 1'b1;
      rx_stop  = 1'b1;
      err_cnt  = 16'd0;
      led_req  = 3'd0;
      wr_ptr   = 0;
      rd_ptr   = 0;
      link_expect.delete();
    end else begin
      if (in_valid && in_ready)
        link_expect.push_back(advance_link(ps2hl_pkg::op_t'(in_operation), in_data_line,
                                           in_edge_gap_long, in_num_lock,
                                           in_caps_lock, in_scroll_lock));
      if (out_valid && out_ready) begin
        seen.drive_valid   = out_drive_valid;
        seen.drive_level   = out_drive_level;
        seen.start_request = out_start_request;
        seen.send_failed   = out_send_failed;
        seen.byte_valid    = out_byte_valid;
        seen.byte_value    = out_byte_value;
        seen.frame_errors  = out_frame_errors;
        seen.link_mode     = ps2hl_pkg::mode_t'(out_link_mode);
        if (link_expect.size() == 0) begin
          note_fault("result transfer with nothing outstanding", '0, seen);
        end else begin
          want = link_expect.pop_front();
          if (seen !== want)
            note_fault("result mismatch", want, seen);
        end
      end
    end
    pending <= link_expect.size();
  end

endmodule

[tb/tb_ps2_host_link_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_host_link_core
// Stimulus and verdict for the PS/2 host link core: a few directed events,
// then random device frames, LED command exchanges, pops and noise, with
// random idling on both channels and a separate checker doing the scoring.
// ----------------------------------------------------------------------------
module tb_ps2_host_link_core;

  localparam int RUN_ITEMS    = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  // drain bursts run the ring past empty
  localparam int DEPTH_POPS   = ps2hl_pkg::FIFO_DEPTH_DEFAULT;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_operation = ps2hl_pkg::OP_NOP;
  logic        in_data_line = 1'b1;
  logic        in_edge_gap_long = 1'b0;
  logic        in_num_lock = 1'b0;
  logic        in_caps_lock = 1'b0;
  logic        in_scroll_lock = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_drive_valid;
  logic        out_drive_level;
  logic        out_start_request;
  logic        out_send_failed;
  logic        out_byte_valid;
  logic [7:0]  out_byte_value;
  logic [15:0] out_frame_errors;
  logic [1:0]  out_link_mode;

  int mismatch_total;
  int pending;
  int sent_items = 0;
  int cycles = 0;
  int hold_asks = 0;
  int hold_done = 0;
  bit calm_tx = 1'b0;
  bit dirty = 1'b1;

  always #5 clk = ~clk;

  ps2_host_link_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_data_line      (in_data_line),
    .in_edge_gap_long  (in_edge_gap_long),
    .in_num_lock       (in_num_lock),
    .in_caps_lock      (in_caps_lock),
    .in_scroll_lock    (in_scroll_lock),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_valid   (out_drive_valid),
    .out_drive_level   (out_drive_level),
    .out_start_request (out_start_request),
    .out_send_failed   (out_send_failed),
    .out_byte_valid    (out_byte_valid),
    .out_byte_value    (out_byte_value),
    .out_frame_errors  (out_frame_errors),
    .out_link_mode     (out_link_mode)
  );

  ps2_host_link_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_data_line      (in_data_line),
    .in_edge_gap_long  (in_edge_gap_long),
    .in_num_lock       (in_num_lock),
    .in_caps_lock      (in_caps_lock),
    .in_scroll_lock    (in_scroll_lock),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_valid   (out_drive_valid),
    .out_drive_level   (out_drive_level),
    .out_start_request (out_start_request),
    .out_send_failed   (out_send_failed),
    .out_byte_valid    (out_byte_valid),
    .out_byte_value    (out_byte_value),
    .out_frame_errors  (out_frame_errors),
    .out_link_mode     (out_link_mode),
    .mismatch_total    (mismatch_total),
    .pending           (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL ps2_host_link_core");
      $finish;
    end
  end

  function automatic logic coin();
    coin = $urandom_range(0, 1) != 0;
  endfunction

  // Offer one item and hold it until the transfer; valid stays up for
  // back-to-back items so it is never dropped and raised in one step
  task automatic put_item(input ps2hl_pkg::op_t op, input logic d, input logic g,
                          input logic n, input logic c, input logic s);
    int idle;
    idle = calm_tx ? 0 : $urandom_range(0, 18);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_data_line     <= d;
    in_edge_gap_long <= g;
    in_num_lock      <= n;
    in_caps_lock     <= c;
    in_scroll_lock   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != ps2hl_pkg::OP_NOP) sent_items++;
  endtask

  task automatic edge_bit(input logic d, input logic g);
    put_item(ps2hl_pkg::OP_EDGE, d, g, coin(), coin(), coin());
  endtask

  task automatic pop_byte();
    put_item(ps2hl_pkg::OP_POP, coin(), coin(), coin(), coin(), coin());
  endtask

  // Device to host frame; a long gap on the start bit resyncs after junk
  task automatic put_frame(input logic [7:0] b, input bit bad_par, input bit bad_stop);
    edge_bit(1'b0, dirty ? 1'b1 : coin());
    dirty = 1'b0;
    for (int k = 0; k < 8; k++) edge_bit(b[k], 1'b0);
    edge_bit(~(^b) ^ bad_par, 1'b0);
    edge_bit(~bad_stop, 1'b0);
  endtask

  // Device clocks a host byte out: data, parity, stop, then the ack bit
  task automatic clock_out_byte(input bit nack);
    for (int k = 0; k < 10; k++) edge_bit(coin(), coin());
    edge_bit(nack, coin());
  endtask

  // LED update: command, device reply, LED byte; resends loop back
  task automatic led_exchange();
    bit         busy;
    bit         nack;
    int         pick;
    logic [7:0] other;
    put_item(ps2hl_pkg::OP_LED, coin(), coin(), coin(), coin(), coin());
    busy = 1'b1;
    while (busy) begin
      nack = $urandom_range(0, 9) == 0;
      clock_out_byte(nack);
      if (nack) begin
        busy = 1'b0;
      end else begin
        if ($urandom_range(0, 7) == 0) pop_byte();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // stray reply is ignored while waiting
          other = 8'($urandom_range(0, 255));
          if (other == ps2hl_pkg::REPLY_ACK || other == ps2hl_pkg::REPLY_RESEND)
            other ^= 8'h01;
          put_frame(other, 1'b0, 1'b0);
        end else if (pick == 1) begin
          put_frame(ps2hl_pkg::REPLY_ACK, 1'b1, 1'b0);
        end
        if (pick == 2 || pick == 3) begin
          put_frame(ps2hl_pkg::REPLY_RESEND, 1'b0, 1'b0);
        end else begin
          put_frame(ps2hl_pkg::REPLY_ACK, 1'b0, 1'b0);
          clock_out_byte($urandom_range(0, 9) == 0);
          busy = 1'b0;
        end
      end
    end
  endtask

  // Sender goes quiet until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, calm runs and one long hold-off on request
  initial begin : result_side
    int stall;
    int calm_left;
    calm_left = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_asks != hold_done) begin
        hold_done++;
        stall = LONG_HOLD;
      end else if (calm_left > 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
        if ($urandom_range(0, 39) == 0) calm_left = 40;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin : item_side
    int  pick;
    int  cnt;
    bit  held;
    bit  paused;
    bit  bad_p;
    held   = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, no-op, high start bit, 0xFF frame and its pop,
    // then an LED request restarted part way through the command
    pop_byte();
    put_item(ps2hl_pkg::OP_NOP, coin(), coin(), coin(), coin(), coin());
    edge_bit(1'b1, 1'b1);
    put_frame(8'hFF, 1'b0, 1'b0);
    pop_byte();
    put_item(ps2hl_pkg::OP_LED, coin(), coin(), 1'b1, 1'b1, 1'b1);
    for (int k = 0; k < 3; k++) edge_bit(coin(), coin());
    put_item(ps2hl_pkg::OP_LED, coin(), coin(), 1'b0, 1'b0, 1'b0);
    led_exchange();

    while (sent_items < RUN_ITEMS) begin
      if (!held && sent_items >= 300) begin
        hold_asks++;
        held = 1'b1;
      end
      if (!paused && sent_items >= 650) begin
        wait_drained();
        paused = 1'b1;
      end
      calm_tx = $urandom_range(0, 5) == 0;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        put_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else if (pick < 45) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) pop_byte();
      end else if (pick < 65) begin
        led_exchange();
      end else if (pick < 72) begin
        bad_p = coin();
        put_frame(8'($urandom_range(0, 255)), bad_p, ~bad_p | coin());
      end else if (pick < 78) begin
        edge_bit(1'b1, 1'b1);
      end else if (pick < 84) begin
        // frame cut short, next frame resyncs on a long gap
        cnt = $urandom_range(1, 10);
        edge_bit(1'b0, 1'b1);
        repeat (cnt - 1) edge_bit(coin(), 1'b0);
        dirty = 1'b1;
      end else if (pick < 90) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) begin
          case ($urandom_range(0, 2))
            0:       edge_bit(coin(), coin());
            1:       put_item(ps2hl_pkg::OP_NOP, coin(), coin(), coin(), coin(), coin());
            default: pop_byte();
          endcase
        end
        dirty = 1'b1;
      end else if (pick < 94) begin
        // LED request lands in the middle of a command send
        put_item(ps2hl_pkg::OP_LED, coin(), coin(), coin(), coin(), coin());
        cnt = $urandom_range(1, 9);
        repeat (cnt) edge_bit(coin(), coin());
        led_exchange();
      end else begin
        repeat (DEPTH_POPS) pop_byte();
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0)
      $display("PASS ps2_host_link_core");
    else
      $display("FAIL ps2_host_link_core");
    $finish;
  end

endmodule

[filelist.f]
src/ps2hl_pkg.sv
src/ps2hl_fifo_mem.sv
src/ps2hl_link_ctrl.sv
src/ps2_host_link_core.sv
tb/ps2_host_link_checker.sv
tb/tb_ps2_host_link_core.sv
